FILE: sv/tmpl_pkg.sv
// shared types and constants for the triangle mesh point locator
`default_nettype none
package tmpl_pkg;

  localparam int COORD_W       = 16;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int MAX_VERTICES  = 1024;
  localparam int MAX_TRIANGLES = 1024;
  localparam int VTX_AW        = $clog2(MAX_VERTICES);
  localparam int TRI_AW        = $clog2(MAX_TRIANGLES);
  localparam int DIFF_W        = COORD_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int TERM_W        = PROD_W + 1;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_QUERY    = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    idx_t a;
    idx_t b;
    idx_t c;
  } tri_t;

  typedef struct packed {
    logic    valid;
    vertex_t p;
    vertex_t va;
    vertex_t vb;
    vertex_t vc;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic covered;
  } edge_rsp_t;

endpackage
`default_nettype wire

FILE: sv/tmpl_vertex_ram.sv
// vertex store: one write port, two registered read ports
`default_nettype none
module tmpl_vertex_ram #(
  parameter int DEPTH = tmpl_pkg::MAX_VERTICES,
  parameter int WIDTH = $bits(tmpl_pkg::vertex_t)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  output      logic [WIDTH-1:0]         rdata0,
  input  wire logic                     re1,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output      logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rdata0 <= mem[raddr0];
    end
    if (re1) begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

FILE: sv/tmpl_tri_ram.sv
// triangle store: one write port, one registered read port
`default_nettype none
module tmpl_tri_ram #(
  parameter int DEPTH = tmpl_pkg::MAX_TRIANGLES,
  parameter int WIDTH = $bits(tmpl_pkg::tri_t)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/tmpl_edge_unit.sv
// three-stage edge function pipeline: differences, products, signs
`default_nettype none
module tmpl_edge_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tmpl_pkg::edge_req_t req,
  output      tmpl_pkg::edge_rsp_t rsp
);
  import tmpl_pkg::*;

  logic signed [DIFF_W-1:0] da_r [3];
  logic signed [DIFF_W-1:0] db_r [3];
  logic signed [DIFF_W-1:0] dc_r [3];
  logic signed [DIFF_W-1:0] dd_r [3];
  logic signed [PROD_W-1:0] m1_r [3];
  logic signed [PROD_W-1:0] m2_r [3];
  logic [2:0] neg_r;
  logic [2:0] pos_r;
  logic v1_r, v2_r, v3_r;

  coord_t ux [3];
  coord_t uy [3];
  coord_t wx [3];
  coord_t wy [3];

  // edges a->b, b->c, c->a
  always_comb begin
    ux[0] = req.va.x; uy[0] = req.va.y; wx[0] = req.vb.x; wy[0] = req.vb.y;
    ux[1] = req.vb.x; uy[1] = req.vb.y; wx[1] = req.vc.x; wy[1] = req.vc.y;
    ux[2] = req.vc.x; uy[2] = req.vc.y; wx[2] = req.va.x; wy[2] = req.va.y;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      da_r[k] <= DIFF_W'(req.p.x) - DIFF_W'(wx[k]);
      db_r[k] <= DIFF_W'(uy[k]) - DIFF_W'(wy[k]);
      dc_r[k] <= DIFF_W'(ux[k]) - DIFF_W'(wx[k]);
      dd_r[k] <= DIFF_W'(req.p.y) - DIFF_W'(wy[k]);
      m1_r[k] <= da_r[k] * db_r[k];
      m2_r[k] <= dc_r[k] * dd_r[k];
    end
  end

  // exact sign of the cross product, one bit wider than the products
  always_ff @(posedge clk) begin
    logic signed [TERM_W-1:0] t;
    for (int k = 0; k < 3; k++) begin
      t = TERM_W'(m1_r[k]) - TERM_W'(m2_r[k]);
      neg_r[k] <= t[TERM_W-1];
      pos_r[k] <= !t[TERM_W-1] && (t != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign rsp.valid   = v3_r;
  assign rsp.covered = !((|neg_r) && (|pos_r));

endmodule
`default_nettype wire

FILE: sv/triangle_mesh_point_locate.sv
// triangle mesh point locator: top level with the scan sequencer
// a load is written at its accept; a query's result is taken once the scan of t triangles ends,
// where t is the number of triangles tested (up to the first hit, at most triangle_count capped to MAX_TRIANGLES)
// each triangle passes through: triangle read, two vertex reads, edge setup, 3-stage edge unit
// throughput: a load per cycle while not busy; a query holds busy for its whole scan; the strobe never stalls
// synchronous active-low reset clears the sequencer, the strobe, triangle_count and the edge unit valids only
`default_nettype none
module triangle_mesh_point_locate (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [1:0]                   in_kind,
  input  wire tmpl_pkg::idx_t               in_slot,
  input  wire tmpl_pkg::coord_t             in_x,
  input  wire tmpl_pkg::coord_t             in_y,
  input  wire tmpl_pkg::idx_t               in_corner_a,
  input  wire tmpl_pkg::idx_t               in_corner_b,
  input  wire tmpl_pkg::idx_t               in_corner_c,
  output      logic                         out_valid,
  output      logic                         out_found,
  output      tmpl_pkg::idx_t               out_hit_triangle,
  output      tmpl_pkg::idx_t               out_hit_corner_a,
  output      tmpl_pkg::idx_t               out_hit_corner_b,
  output      tmpl_pkg::idx_t               out_hit_corner_c,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [tmpl_pkg::CNT_W-1:0]   cfg_data
);
  import tmpl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TRI  = 6'b000010,
    ST_VAB  = 6'b000100,
    ST_VC   = 6'b001000,
    ST_EVAL = 6'b010000,
    ST_WAIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r;
  vertex_t p_r, p_nxt;
  vertex_t va_r, vb_r;
  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_found_nxt;
  idx_t out_tri_r, out_tri_nxt;
  tri_t out_corners_r, out_corners_nxt;

  logic accept;
  logic [CNT_W-1:0] n_sat;
  logic last;

  logic vtx_we, tri_we;
  logic vtx_re0, vtx_re1, tri_re;
  logic [VTX_AW-1:0] vtx_addr0, vtx_addr1;
  logic [$bits(vertex_t)-1:0] vtx_q0, vtx_q1;
  logic [$bits(tri_t)-1:0] tri_q;
  tri_t tri_cur;
  edge_req_t e_req;
  edge_rsp_t e_rsp;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign tri_cur   = tri_t'(tri_q);

  assign n_sat = (count_r > CNT_W'(MAX_TRIANGLES)) ? CNT_W'(MAX_TRIANGLES) : count_r;
  assign last  = ((idx_r + CNT_W'(1)) == n_sat);

  // loads write at the accept edge, so a later query never overlaps them
  assign vtx_we = accept && (in_kind == KIND_VERTEX) && (int'(in_slot) < MAX_VERTICES);
  assign tri_we = accept && (in_kind == KIND_TRIANGLE) && (int'(in_slot) < MAX_TRIANGLES);

  assign tri_re    = (state_r == ST_TRI);
  assign vtx_re0   = (state_r == ST_VAB) || (state_r == ST_VC);
  assign vtx_re1   = (state_r == ST_VAB);
  // corner indices wrap to the vertex store depth
  assign vtx_addr0 = (state_r == ST_VAB) ? tri_cur.a[VTX_AW-1:0] : tri_cur.c[VTX_AW-1:0];
  assign vtx_addr1 = tri_cur.b[VTX_AW-1:0];

  tmpl_vertex_ram #(
    .DEPTH(MAX_VERTICES),
    .WIDTH($bits(vertex_t))
  ) u_vertex_ram (
    .clk    (clk),
    .we     (vtx_we),
    .waddr  (in_slot[VTX_AW-1:0]),
    .wdata  ({in_x, in_y}),
    .re0    (vtx_re0),
    .raddr0 (vtx_addr0),
    .rdata0 (vtx_q0),
    .re1    (vtx_re1),
    .raddr1 (vtx_addr1),
    .rdata1 (vtx_q1)
  );

  tmpl_tri_ram #(
    .DEPTH(MAX_TRIANGLES),
    .WIDTH($bits(tri_t))
  ) u_tri_ram (
    .clk   (clk),
    .we    (tri_we),
    .waddr (in_slot[TRI_AW-1:0]),
    .wdata ({in_corner_a, in_corner_b, in_corner_c}),
    .re    (tri_re),
    .raddr (idx_r[TRI_AW-1:0]),
    .rdata (tri_q)
  );

  always_comb begin
    e_req.valid = (state_r == ST_EVAL);
    e_req.p     = p_r;
    e_req.va    = va_r;
    e_req.vb    = vb_r;
    e_req.vc    = vertex_t'(vtx_q0);
  end

  tmpl_edge_unit u_edge_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (e_req),
    .rsp   (e_rsp)
  );

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    p_nxt           = p_r;
    out_valid_nxt   = 1'b0;
    out_found_nxt   = out_found_r;
    out_tri_nxt     = out_tri_r;
    out_corners_nxt = out_corners_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_QUERY)) begin
          p_nxt   = {in_x, in_y};
          idx_nxt = '0;
          if (n_sat == '0) begin
            out_valid_nxt   = 1'b1;
            out_found_nxt   = 1'b0;
            out_tri_nxt     = '0;
            out_corners_nxt = '0;
          end else begin
            state_nxt = ST_TRI;
          end
        end
      end
      ST_TRI:  state_nxt = ST_VAB;
      ST_VAB:  state_nxt = ST_VC;
      ST_VC:   state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (e_rsp.valid) begin
          if (e_rsp.covered) begin
            out_valid_nxt   = 1'b1;
            out_found_nxt   = 1'b1;
            out_tri_nxt     = idx_r[IDX_W-1:0];
            out_corners_nxt = tri_cur;
            state_nxt       = ST_IDLE;
          end else if (last) begin
            out_valid_nxt   = 1'b1;
            out_found_nxt   = 1'b0;
            out_tri_nxt     = '0;
            out_corners_nxt = '0;
            state_nxt       = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_TRI;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    p_r           <= p_nxt;
    out_found_r   <= out_found_nxt;
    out_tri_r     <= out_tri_nxt;
    out_corners_r <= out_corners_nxt;
    if (state_r == ST_VC) begin
      va_r <= vertex_t'(vtx_q0);
      vb_r <= vertex_t'(vtx_q1);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_hit_triangle = out_tri_r;
  assign out_hit_corner_a = out_corners_r.a;
  assign out_hit_corner_b = out_corners_r.b;
  assign out_hit_corner_c = out_corners_r.c;

`ifndef SYNTHESIS
  // an accepted query either starts the scan or answers at once
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_QUERY)) |=> (busy || out_valid))
    else $error("query accepted without scan or result");

  // a hit from the edge unit gives a found result in the next cycle
  a_hit_reported: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WAIT) && e_rsp.valid && e_rsp.covered) |=> (out_valid && out_found))
    else $error("hit not reported");

  // a found slot lies inside the searched range
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> ({1'b0, out_hit_triangle} < n_sat))
    else $error("hit slot beyond triangle count");

  // edge results only arrive while the sequencer waits for them
  a_edge_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    e_rsp.valid |-> (state_r == ST_WAIT))
    else $error("edge result outside wait state");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/point_locate_checker.sv
// checker for the triangle mesh point locator: mirrors the mesh, predicts and compares results
`timescale 1ns / 100ps
`default_nettype none
module point_locate_checker
  import tmpl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         in_kind,
  input  wire idx_t               in_slot,
  input  wire coord_t             in_x,
  input  wire coord_t             in_y,
  input  wire idx_t               in_corner_a,
  input  wire idx_t               in_corner_b,
  input  wire idx_t               in_corner_c,
  input  wire logic               out_valid,
  input  wire logic               out_found,
  input  wire idx_t               out_hit_triangle,
  input  wire idx_t               out_hit_corner_a,
  input  wire idx_t               out_hit_corner_b,
  input  wire idx_t               out_hit_corner_c,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [CNT_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic found;
    idx_t slot;
    idx_t a;
    idx_t b;
    idx_t c;
  } locate_result_t;

  coord_t               mesh_x [MAX_VERTICES];
  coord_t               mesh_y [MAX_VERTICES];
  tri_t                 mesh_tri [MAX_TRIANGLES];
  logic [CNT_W-1:0]     tri_count;
  locate_result_t       expected_hits [$];
  locate_result_t       want;
  locate_result_t       got;
  int                   errs;

  initial begin
    errs = 0;
    tri_count = '0;
    fail_count = 0;
    pending = 0;
  end

  // sign of the z component of (p - w) x (u - w); exact in 64 bits
  function automatic int cross_sign(longint px, longint py, longint ux, longint uy,
                                    longint wx, longint wy);
    longint v;
    v = (px - wx) * (uy - wy) - (ux - wx) * (py - wy);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic bit covers(coord_t px, coord_t py, tri_t t);
    longint ax, ay, bx, by, cx, cy;
    int d1, d2, d3;
    bit neg, pos;
    ax = mesh_x[t.a];
    ay = mesh_y[t.a];
    bx = mesh_x[t.b];
    by = mesh_y[t.b];
    cx = mesh_x[t.c];
    cy = mesh_y[t.c];
    d1 = cross_sign(px, py, ax, ay, bx, by);
    d2 = cross_sign(px, py, bx, by, cx, cy);
    d3 = cross_sign(px, py, cx, cy, ax, ay);
    neg = (d1 < 0) || (d2 < 0) || (d3 < 0);
    pos = (d1 > 0) || (d2 > 0) || (d3 > 0);
    // on an edge or degenerate: no mixed signs, counts as inside
    return !(neg && pos);
  endfunction

  function automatic locate_result_t locate_point(coord_t px, coord_t py);
    locate_result_t res;
    int unsigned n;
    tri_t t;
    res = '0;
    n = (tri_count > MAX_TRIANGLES) ? MAX_TRIANGLES : tri_count;
    for (int unsigned i = 0; i < n; i++) begin
      t = mesh_tri[i];
      if (covers(px, py, t)) begin
        res.found = 1'b1;
        res.slot = idx_t'(i);
        res.a = t.a;
        res.b = t.b;
        res.c = t.c;
        return res;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [IDX_W-1:0] exp_v,
                             input logic [IDX_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tri_count = '0;
      expected_hits.delete();
    end else begin
      // result first: a strobe at this edge belongs to an earlier query
      if (out_valid) begin
        got = '{out_found, out_hit_triangle, out_hit_corner_a, out_hit_corner_b,
                out_hit_corner_c};
        if (expected_hits.size() == 0) begin
          $error("result transaction with no query outstanding");
          errs++;
        end else begin
          want = expected_hits.pop_front();
          check_field("found", IDX_W'(want.found), IDX_W'(got.found));
          check_field("hit_triangle", want.slot, got.slot);
          check_field("hit_corner_a", want.a, got.a);
          check_field("hit_corner_b", want.b, got.b);
          check_field("hit_corner_c", want.c, got.c);
        end
      end
      if (cfg_valid && cfg_ready)
        tri_count = cfg_data;
      if (start && !busy) begin
        case (in_kind)
          KIND_VERTEX: begin
            mesh_x[in_slot] = in_x;
            mesh_y[in_slot] = in_y;
          end
          KIND_TRIANGLE: begin
            mesh_tri[in_slot] = '{in_corner_a, in_corner_b, in_corner_c};
          end
          KIND_QUERY: begin
            expected_hits.push_back(locate_point(in_x, in_y));
          end
          default: ;
        endcase
      end
    end
    pending <= expected_hits.size();
    fail_count <= errs;
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench top for the triangle mesh point locator: stimulus, configuration and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import tmpl_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 520;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_kind;
  idx_t               in_slot;
  coord_t             in_x;
  coord_t             in_y;
  idx_t               in_corner_a;
  idx_t               in_corner_b;
  idx_t               in_corner_c;
  logic               out_valid;
  logic               out_found;
  idx_t               out_hit_triangle;
  idx_t               out_hit_corner_a;
  idx_t               out_hit_corner_b;
  idx_t               out_hit_corner_c;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data;
  int                 fail_count;
  int                 pending;

  // what the stimulus knows of the mesh, so that queries read only written entries
  bit                 vtx_ok [MAX_VERTICES];
  bit                 tri_ok [MAX_TRIANGLES];
  int                 mx [MAX_VERTICES];
  int                 my [MAX_VERTICES];
  idx_t               ta [MAX_TRIANGLES];
  idx_t               tb [MAX_TRIANGLES];
  idx_t               tc [MAX_TRIANGLES];
  idx_t               vtx_pool [$];
  int                 tri_prefix;
  int                 cur_count;
  int                 burst_left;
  int                 random_items;

  triangle_mesh_point_locate dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_corner_a      (in_corner_a),
    .in_corner_b      (in_corner_b),
    .in_corner_c      (in_corner_c),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_hit_triangle (out_hit_triangle),
    .out_hit_corner_a (out_hit_corner_a),
    .out_hit_corner_b (out_hit_corner_b),
    .out_hit_corner_c (out_hit_corner_c),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  point_locate_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_corner_a      (in_corner_a),
    .in_corner_b      (in_corner_b),
    .in_corner_c      (in_corner_c),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_hit_triangle (out_hit_triangle),
    .out_hit_corner_a (out_hit_corner_a),
    .out_hit_corner_b (out_hit_corner_b),
    .out_hit_corner_c (out_hit_corner_c),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2, 3: return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  function automatic idx_t rand_idx();
    return idx_t'($urandom);
  endfunction

  function automatic idx_t pick_corner();
    return vtx_pool[$urandom_range(0, vtx_pool.size() - 1)];
  endfunction

  // one transaction; the sender idles between bursts of random length
  task automatic send_item(input logic [1:0] kind, input idx_t slot, input coord_t x,
                           input coord_t y, input idx_t a, input idx_t b, input idx_t c);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    in_kind <= kind;
    in_slot <= slot;
    in_x <= x;
    in_y <= y;
    in_corner_a <= a;
    in_corner_b <= b;
    in_corner_c <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_vertex(input idx_t s, input coord_t x, input coord_t y);
    if (!vtx_ok[s])
      vtx_pool.push_back(s);
    vtx_ok[s] = 1'b1;
    mx[s] = x;
    my[s] = y;
    send_item(KIND_VERTEX, s, x, y, rand_idx(), rand_idx(), rand_idx());
  endtask

  task automatic load_triangle(input idx_t s, input idx_t a, input idx_t b, input idx_t c);
    tri_ok[s] = 1'b1;
    ta[s] = a;
    tb[s] = b;
    tc[s] = c;
    while (tri_prefix < MAX_TRIANGLES && tri_ok[tri_prefix])
      tri_prefix++;
    send_item(KIND_TRIANGLE, s, rand_coord(), rand_coord(), a, b, c);
  endtask

  task automatic query(input coord_t x, input coord_t y);
    send_item(KIND_QUERY, rand_idx(), x, y, rand_idx(), rand_idx(), rand_idx());
  endtask

  task automatic random_query();
    int r;
    int t;
    idx_t v;
    r = $urandom_range(0, 9);
    t = (cur_count > 0) ? $urandom_range(0, cur_count - 1) : 0;
    if (cur_count > 0 && r < 4) begin
      case ($urandom_range(0, 2))
        0: v = ta[t];
        1: v = tb[t];
        default: v = tc[t];
      endcase
      query(coord_t'(mx[v]), coord_t'(my[v]));
    end else if (cur_count > 0 && r < 7) begin
      // near the centroid, with a little jitter to land on both sides of thin triangles
      query(coord_t'((mx[ta[t]] + mx[tb[t]] + mx[tc[t]]) / 3 + int'($urandom_range(0, 6)) - 3),
            coord_t'((my[ta[t]] + my[tb[t]] + my[tc[t]]) / 3 + int'($urandom_range(0, 6)) - 3));
    end else begin
      query(rand_coord(), rand_coord());
    end
  endtask

  // register writes only once the block has drained
  task automatic set_count(input int v);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4 + $urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_count = v;
  endtask

  initial begin
    int r;
    int cnt_cap;
    int phase_len;
    idx_t s;

    tri_prefix = 0;
    cur_count = 0;
    burst_left = 0;
    random_items = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_VERTEX;
    in_slot <= '0;
    in_x <= '0;
    in_y <= '0;
    in_corner_a <= '0;
    in_corner_b <= '0;
    in_corner_c <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty mesh, ignored kind, extreme corners, degenerate triangles
    set_count(0);
    query(16'sh8000, 16'sh7FFF);
    send_item(KIND_UNUSED, 10'h3FF, 16'sh7FFF, 16'sh8000, 10'h3FF, 10'h3FF, 10'h3FF);
    load_vertex(10'd0, 16'sh8000, 16'sh8000);
    load_vertex(10'd1, 16'sh7FFF, 16'sh8000);
    load_vertex(10'd2, 16'sh8000, 16'sh7FFF);
    load_vertex(10'd3, 16'sh7FFF, 16'sh7FFF);
    load_vertex(10'd4, 16'sh0000, 16'sh0000);
    load_vertex(10'd5, 16'sd100, 16'sd100);
    load_vertex(10'd6, 16'sd200, 16'sd200);
    load_vertex(10'd1023, -16'sd1, -16'sd1);
    load_triangle(10'd0, 10'd0, 10'd1, 10'd2);
    load_triangle(10'd1, 10'd4, 10'd5, 10'd6);     // collinear
    load_triangle(10'd2, 10'd4, 10'd3, 10'd1);
    load_triangle(10'd3, 10'd1023, 10'd1023, 10'd1023);  // collapsed to a point
    set_count(3);
    query(16'sh8000, 16'sh8000);
    query(-16'sd1, 16'sd0);
    query(16'sd300, 16'sd300);
    query(-16'sd20000, 16'sd30000);
    query(16'sd30000, 16'sd0);
    set_count(4);
    query(-16'sd20000, 16'sd30000);
    query(16'sh7FFF, 16'sh7FFF);

    // random phases, each with its own triangle count no larger than the loaded prefix
    while (random_items < RANDOM_ITEMS) begin
      cnt_cap = (tri_prefix < 48) ? tri_prefix : 48;
      r = $urandom_range(0, 5);
      if (r == 0)
        set_count(0);
      else if (r == 1)
        set_count(cnt_cap);
      else if (r == 2)
        set_count((cnt_cap > 0) ? 1 : 0);
      else
        set_count($urandom_range(0, cnt_cap));
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        r = $urandom_range(0, 19);
        if (r < 5) begin
          s = $urandom_range(0, 1) ? idx_t'($urandom_range(0, 63)) : rand_idx();
          load_vertex(s, rand_coord(), rand_coord());
          random_items++;
        end else if (r < 9) begin
          r = $urandom_range(0, 9);
          if (r < 5 && tri_prefix < MAX_TRIANGLES)
            s = idx_t'(tri_prefix);
          else if (r < 8 && tri_prefix > 0)
            s = idx_t'($urandom_range(0, tri_prefix - 1));
          else
            s = rand_idx();
          load_triangle(s, pick_corner(), pick_corner(), pick_corner());
          random_items++;
        end else if (r == 9) begin
          send_item(KIND_UNUSED, rand_idx(), rand_coord(), rand_coord(),
                    rand_idx(), rand_idx(), rand_idx());
          random_items++;
        end else begin
          random_query();
          random_items++;
        end
      end
    end

    // counts at and above the store depth: a corner of slot 0 always hits there,
    // so the scan never reaches unwritten slots
    set_count(MAX_TRIANGLES);
    query(coord_t'(mx[ta[0]]), coord_t'(my[ta[0]]));
    query(coord_t'(mx[tb[0]]), coord_t'(my[tb[0]]));
    set_count(2047);
    query(coord_t'(mx[tc[0]]), coord_t'(my[tc[0]]));
    query(coord_t'(mx[ta[0]]), coord_t'(my[ta[0]]));

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
sv/tmpl_pkg.sv
sv/tmpl_vertex_ram.sv
sv/tmpl_tri_ram.sv
sv/tmpl_edge_unit.sv
sv/triangle_mesh_point_locate.sv
tb/sv/point_locate_checker.sv
tb/sv/tb_top.sv
